FILE: hw/rtl/dtt_pkg.sv
// Package with the shared types, constants and functions of the transposition table.
`timescale 1ns / 1ps
package dtt_pkg;

   localparam int CLUSTER_BITS_DEF = 12;
   localparam int WAYS_DEF = 8;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_NEW_SEARCH = 2'd2;

   localparam logic [1:0] OUT_FRESH = 2'd0;
   localparam logic [1:0] OUT_EXACT = 2'd1;
   localparam logic [1:0] OUT_DOMINATING = 2'd2;
   localparam logic [1:0] OUT_EVICTED = 2'd3;

   localparam logic [31:0] REPEAT_MARK = 32'hFFFF_FFFF;
   localparam logic [31:0] BORROW_BITS = 32'h0922_2220;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] key;
      logic [31:0] hand;
      logic [7:0]  depth;
      logic [2:0]  slot;
      logic [26:0] proof_number;
      logic [26:0] disproof_number;
      logic [31:0] search_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  found_slot;
      logic [1:0]  outcome;
      logic [26:0] result_proof;
      logic [26:0] result_disproof;
      logic [31:0] result_count;
      logic [31:0] result_hand;
   } rsp_type;

   typedef struct packed {
      logic [31:0] tag;
      logic [7:0]  depth;
      logic [31:0] hand;
      logic [26:0] pn;
      logic [26:0] dn;
      logic [31:0] count;
      logic [15:0] age;
   } entry_type;

   typedef struct packed {
      logic ready;
      logic accept;
      logic commit;
      logic clear_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic clear_last;
   } ctrl_status_type;

   function automatic logic dominates(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return (diff & BORROW_BITS) == 32'd0;
   endfunction

   // A proven entry serves a hand that dominates its own, a disproven one a dominated hand.
   function automatic logic usable(input entry_type e, input logic [31:0] hand);
      logic res;
      res = 1'b0;
      if (e.pn == 27'd0) begin
         res = dominates(hand, e.hand) && (e.count != REPEAT_MARK);
      end else if (e.dn == 27'd0) begin
         res = dominates(e.hand, hand) && (e.count != REPEAT_MARK);
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/dtt_req_if.sv
// Request channel interface carrying one command beat.
`timescale 1ns / 1ps
interface dtt_req_if;
   logic             valid;
   logic             ready;
   dtt_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/dtt_rsp_if.sv
// Response channel interface carrying one result beat.
`timescale 1ns / 1ps
interface dtt_rsp_if;
   logic             valid;
   logic             ready;
   dtt_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/dtt_ctrl.sv
// Controller state machine sequencing the clearing pass and each command.
`timescale 1ns / 1ps
module dtt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  dtt_pkg::ctrl_status_type status,
   output dtt_pkg::ctrl_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_EVAL   = 4'b0100,
      S_DECIDE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (status.req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

FILE: hw/rtl/dtt_datapath.sv
// Datapath with the cluster memory, way comparison, replacement choice and result register.
`timescale 1ns / 1ps
module dtt_datapath #(
   parameter int CLUSTER_BITS = dtt_pkg::CLUSTER_BITS_DEF,
   parameter int WAYS = dtt_pkg::WAYS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dtt_pkg::ctrl_cmd_type    cmd,
   output dtt_pkg::ctrl_status_type status,
   input  logic                     req_valid,
   input  dtt_pkg::req_type         req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dtt_pkg::rsp_type         rsp_payload
);

   localparam int ROWS = 2 ** CLUSTER_BITS;
   localparam int WB = $clog2(WAYS);

   typedef dtt_pkg::entry_type [WAYS-1:0] row_type;

   row_type mem [ROWS];
   row_type row_ff;
   row_type new_row;
   row_type wr_row;
   dtt_pkg::req_type item_ff;
   dtt_pkg::rsp_type rsp_ff;
   dtt_pkg::rsp_type res;
   logic rsp_valid_ff;
   logic [15:0] age_ff;
   logic [15:0] age_in;
   logic [CLUSTER_BITS-1:0] clear_cnt_ff;
   logic [CLUSTER_BITS-1:0] wr_addr;
   logic wr_en;
   logic dec_wr;
   logic age_adv;
   logic [WAYS-1:0] stale_ff, tageq_ff, exact_ff, usable_ff, cpn_ff, cdn_ff;
   logic [WAYS-1:0] stale_in, tageq_in, exact_in, usable_in, cpn_in, cdn_in;

   assign status.req_valid = req_valid;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.clear_last = &clear_cnt_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign wr_en = cmd.clear_step || (cmd.commit && dec_wr);
   assign wr_row = cmd.clear_step ? row_type'('0) : new_row;
   assign wr_addr = cmd.clear_step ? clear_cnt_ff : item_ff.key[CLUSTER_BITS-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         row_ff <= mem[req_payload.key[CLUSTER_BITS-1:0]];
         item_ff <= req_payload;
      end
      stale_ff <= stale_in;
      tageq_ff <= tageq_in;
      exact_ff <= exact_in;
      usable_ff <= usable_in;
      cpn_ff <= cpn_in;
      cdn_ff <= cdn_in;
      if (cmd.commit) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         age_ff <= 16'd0;
         clear_cnt_ff <= '0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.commit && age_adv) begin
            age_ff <= age_in;
         end
         if (cmd.clear_step) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      age_in = age_ff + 16'd1;
      if (age_in == 16'd0) begin
         age_in = 16'd1;
      end
   end

   always_comb begin
      logic solved;
      logic up;
      for (int w = 0; w < WAYS; w++) begin
         solved = (row_ff[w].pn == 27'd0) || (row_ff[w].dn == 27'd0);
         up = dtt_pkg::dominates(row_ff[w].hand, item_ff.hand);
         stale_in[w] = row_ff[w].age != age_ff;
         tageq_in[w] = row_ff[w].tag == item_ff.key[63:32];
         exact_in[w] = tageq_in[w] && (row_ff[w].hand == item_ff.hand)
            && (row_ff[w].depth == item_ff.depth);
         usable_in[w] = dtt_pkg::usable(row_ff[w], item_ff.hand);
         cpn_in[w] = tageq_in[w] && !solved && up;
         cdn_in[w] = tageq_in[w] && !solved && !up
            && dtt_pkg::dominates(item_ff.hand, row_ff[w].hand);
      end
   end

   always_comb begin
      logic ev_any;
      logic [WB-1:0] ev_idx;
      logic fw_found;
      logic fw_stop;
      logic [WB-1:0] fw_idx;
      logic [26:0] max_pn;
      logic [26:0] max_dn;
      logic [31:0] bc;
      logic [31:0] bmc;
      logic [WB-1:0] bi;
      logic [WB-1:0] bmi;
      logic b_ok;
      logic bm_ok;
      logic [WB-1:0] way;
      dtt_pkg::entry_type ent;

      ev_any = 1'b0;
      ev_idx = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (stale_ff[w] || (tageq_ff[w] && (exact_ff[w] || usable_ff[w]))) begin
            ev_any = 1'b1;
            ev_idx = WB'(w);
         end
      end

      fw_found = 1'b0;
      fw_stop = 1'b0;
      fw_idx = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (w > int'(ev_idx)) begin
            if (stale_ff[w]) begin
               fw_stop = 1'b1;
            end else if (!fw_stop && !fw_found && tageq_ff[w] && usable_ff[w]) begin
               fw_found = 1'b1;
               fw_idx = WB'(w);
            end
         end
      end

      max_pn = 27'd1;
      max_dn = 27'd1;
      for (int w = 0; w < WAYS; w++) begin
         if (w < int'(ev_idx)) begin
            if (cpn_ff[w] && (row_ff[w].pn > max_pn)) begin
               max_pn = row_ff[w].pn;
            end
            if (cdn_ff[w] && (row_ff[w].dn > max_dn)) begin
               max_dn = row_ff[w].dn;
            end
         end
      end

      bc = dtt_pkg::REPEAT_MARK;
      bmc = dtt_pkg::REPEAT_MARK;
      bi = '0;
      bmi = '0;
      b_ok = 1'b0;
      bm_ok = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (row_ff[w].pn != 27'd0) begin
            if (row_ff[w].count < bc) begin
               bc = row_ff[w].count;
               bi = WB'(w);
               b_ok = 1'b1;
            end
         end else if (row_ff[w].count < bmc) begin
            bmc = row_ff[w].count;
            bmi = WB'(w);
            bm_ok = 1'b1;
         end
      end

      new_row = row_ff;
      dec_wr = 1'b0;
      age_adv = 1'b0;
      res = '0;
      way = '0;
      ent = '0;

      unique case (item_ff.command)
         dtt_pkg::CMD_LOOKUP: begin
            if (ev_any && !stale_ff[ev_idx]) begin
               if (exact_ff[ev_idx] && !fw_found) begin
                  way = ev_idx;
                  res.outcome = dtt_pkg::OUT_EXACT;
               end else begin
                  way = exact_ff[ev_idx] ? fw_idx : ev_idx;
                  res.outcome = dtt_pkg::OUT_DOMINATING;
               end
               ent = row_ff[way];
            end else begin
               if (ev_any) begin
                  way = ev_idx;
                  ent.pn = max_pn;
                  ent.dn = max_dn;
                  res.outcome = dtt_pkg::OUT_FRESH;
               end else begin
                  way = b_ok ? bi : (bm_ok ? bmi : '0);
                  ent.pn = 27'd1;
                  ent.dn = 27'd1;
                  res.outcome = dtt_pkg::OUT_EVICTED;
               end
               ent.tag = item_ff.key[63:32];
               ent.depth = item_ff.depth;
               ent.hand = item_ff.hand;
               ent.count = 32'd0;
               ent.age = age_ff;
               new_row[way] = ent;
               dec_wr = 1'b1;
            end
            res.found_slot = 3'(way);
            res.result_proof = ent.pn;
            res.result_disproof = ent.dn;
            res.result_count = ent.count;
            res.result_hand = ent.hand;
         end
         dtt_pkg::CMD_UPDATE: begin
            if (int'(item_ff.slot) < WAYS) begin
               way = WB'(item_ff.slot);
               ent = row_ff[way];
               ent.pn = item_ff.proof_number;
               ent.dn = item_ff.disproof_number;
               ent.count = item_ff.search_count;
               ent.hand = item_ff.hand;
               new_row[way] = ent;
               dec_wr = 1'b1;
               res.found_slot = item_ff.slot;
               res.outcome = dtt_pkg::OUT_EXACT;
               res.result_proof = ent.pn;
               res.result_disproof = ent.dn;
               res.result_count = ent.count;
               res.result_hand = ent.hand;
            end
         end
         dtt_pkg::CMD_NEW_SEARCH: begin
            age_adv = 1'b1;
         end
         default: begin
            age_adv = 1'b0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/dominance_aware_transposition_table.sv
// Top level of the dominance-aware set-associative transposition table.
//
// Requests arrive as beats on req_stream (lookup, update of one way, or start
// of a new search generation); every request gives exactly one beat on
// rsp_stream. Each cluster of WAYS entries is one wide row of a single-port
// memory: a request reads its row, compares all ways in parallel, decides,
// and writes the row back when it changed.
// The row read is registered, then the way flags, then the result goes to the
// output register on commit; a new request is accepted only after that commit,
// since the read, evaluate and write-back share the one memory port.
// After reset the block clears every row to zero, one row a cycle, through all
// 2**CLUSTER_BITS rows (4096 by default); req_stream.ready stays low
// meanwhile. The generation counter resets to zero, so a new search
// command must precede the first lookup.
// The response sits in an output register: a stalled receiver does not stop
// the next request from being accepted and processed, which then waits until
// the register is free.
`timescale 1ns / 1ps
module dominance_aware_transposition_table #(
   parameter int CLUSTER_BITS = dtt_pkg::CLUSTER_BITS_DEF,
   parameter int WAYS = dtt_pkg::WAYS_DEF
) (
   input logic       clock,
   input logic       reset,
   dtt_req_if.sink   req_stream,
   dtt_rsp_if.source rsp_stream
);

   dtt_pkg::ctrl_cmd_type    cmd;
   dtt_pkg::ctrl_status_type status;

   assign req_stream.ready = cmd.ready;

   dtt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   dtt_datapath #(
      .CLUSTER_BITS (CLUSTER_BITS),
      .WAYS         (WAYS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_valid   (req_stream.valid),
      .req_payload (req_stream.payload),
      .rsp_valid   (rsp_stream.valid),
      .rsp_ready   (rsp_stream.ready),
      .rsp_payload (rsp_stream.payload)
   );

endmodule
